/* sv/ldo_pkg.sv */
// shared constants and command codes for the load-side disturbance observer
package ldo_pkg;

  // default state width, signed q16.16
  localparam int SIGNAL_WIDTH = 32;

  // fixed field widths
  localparam int IO_W       = 32;
  localparam int COEF_W     = 32;
  localparam int CMD_W      = 2;
  localparam int COEF_IDX_W = 4;

  // coefficient layout: ad row-major first, then bd row-major
  localparam int NUM_COEF = 15;
  localparam int AD_BASE  = 0;
  localparam int BD_BASE  = 9;

  // coefficient fraction bits (q8.24)
  localparam int FRAC_SHIFT = 24;

  // request commands
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

endpackage

/* sv/ldo_row.sv */
// one row of the state update: five products, rounding and saturation
module ldo_row #(
  parameter int SIGNAL_WIDTH = ldo_pkg::SIGNAL_WIDTH
) (
  input  logic signed [SIGNAL_WIDTH-1:0]      x0,
  input  logic signed [SIGNAL_WIDTH-1:0]      x1,
  input  logic signed [SIGNAL_WIDTH-1:0]      x2,
  input  logic signed [ldo_pkg::IO_W-1:0]     u0,
  input  logic signed [ldo_pkg::IO_W-1:0]     u1,
  input  logic signed [ldo_pkg::COEF_W-1:0]   c0,
  input  logic signed [ldo_pkg::COEF_W-1:0]   c1,
  input  logic signed [ldo_pkg::COEF_W-1:0]   c2,
  input  logic signed [ldo_pkg::COEF_W-1:0]   d0,
  input  logic signed [ldo_pkg::COEF_W-1:0]   d1,
  output logic signed [SIGNAL_WIDTH-1:0]      x_new
);

  localparam int SW    = SIGNAL_WIDTH;
  localparam int CW    = ldo_pkg::COEF_W;
  localparam int UW    = ldo_pkg::IO_W;
  localparam int OPW   = (SW > UW) ? SW : UW;
  localparam int PW    = OPW + CW;
  localparam int ACC_W = PW + 3;
  localparam int FRAC  = ldo_pkg::FRAC_SHIFT;
  localparam int RW    = ACC_W - FRAC;

  logic signed [PW-1:0]    x0_e, x1_e, x2_e, u0_e, u1_e;
  logic signed [PW-1:0]    c0_e, c1_e, c2_e, d0_e, d1_e;
  logic signed [PW-1:0]    p0, p1, p2, p3, p4;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] half;
  logic signed [RW-1:0]    rnd;
  logic                    in_range;

  // sign-extend operands to the product width
  assign x0_e = {{(PW-SW){x0[SW-1]}}, x0};
  assign x1_e = {{(PW-SW){x1[SW-1]}}, x1};
  assign x2_e = {{(PW-SW){x2[SW-1]}}, x2};
  assign u0_e = {{(PW-UW){u0[UW-1]}}, u0};
  assign u1_e = {{(PW-UW){u1[UW-1]}}, u1};
  assign c0_e = {{(PW-CW){c0[CW-1]}}, c0};
  assign c1_e = {{(PW-CW){c1[CW-1]}}, c1};
  assign c2_e = {{(PW-CW){c2[CW-1]}}, c2};
  assign d0_e = {{(PW-CW){d0[CW-1]}}, d0};
  assign d1_e = {{(PW-CW){d1[CW-1]}}, d1};

  // exact products, each fits in the product width
  assign p0 = x0_e * c0_e;
  assign p1 = x1_e * c1_e;
  assign p2 = x2_e * c2_e;
  assign p3 = u0_e * d0_e;
  assign p4 = u1_e * d1_e;

  // exact sum plus half an lsb of the q16.16 result
  assign half = ACC_W'(1) <<< (FRAC - 1);
  assign acc  = {{3{p0[PW-1]}}, p0} + {{3{p1[PW-1]}}, p1} + {{3{p2[PW-1]}}, p2}
              + {{3{p3[PW-1]}}, p3} + {{3{p4[PW-1]}}, p4} + half;

  // floor to q16.16
  assign rnd = acc[ACC_W-1:FRAC];

  // saturate to the state width
  assign in_range = (rnd[RW-1:SW-1] == {(RW-SW+1){1'b0}}) ||
                    (rnd[RW-1:SW-1] == {(RW-SW+1){1'b1}});

  always_comb begin
    if (in_range) begin
      x_new = rnd[SW-1:0];
    end else if (rnd[RW-1]) begin
      x_new = {1'b1, {(SW-1){1'b0}}};
    end else begin
      x_new = {1'b0, {(SW-1){1'b1}}};
    end
  end

endmodule

/* sv/load_side_disturbance_observer.sv */
// top level of the load-side disturbance observer for a two-inertia drive
// Takes one request per clock cycle while in_stall is low. A request is
// registered, then executed: a sample request shows the present third
// state element (saturated to 32 bits) as out_load_torque and updates the
// state as x = Ad*x + Bd*u, a write request loads one coefficient (Ad
// row-major at indices 0 to 8, Bd row-major at 9 to 14, higher indices
// ignored), a clear request zeroes the state and code three does nothing.
// The rate is set by the state update loop: fifteen multiply-adds with
// rounding and saturation close combinationally into the state registers.
// A sample's result is registered into a two-entry output queue, which
// keeps requests flowing while the output is stalled; the input stalls
// only once both entries are full and a sample is waiting.
module load_side_disturbance_observer #(
  parameter int SIGNAL_WIDTH = ldo_pkg::SIGNAL_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [ldo_pkg::CMD_W-1:0]             in_cmd,
  input  logic signed [ldo_pkg::IO_W-1:0]       in_motor_speed,
  input  logic signed [ldo_pkg::IO_W-1:0]       in_torsion_torque,
  input  logic [ldo_pkg::COEF_IDX_W-1:0]        in_coef_index,
  input  logic signed [ldo_pkg::COEF_W-1:0]     in_coef_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ldo_pkg::IO_W-1:0]       out_load_torque
);

  localparam int SW = SIGNAL_WIDTH;
  localparam int OW = ldo_pkg::IO_W;
  localparam int CW = ldo_pkg::COEF_W;
  localparam int IW = ldo_pkg::COEF_IDX_W;
  localparam int NC = ldo_pkg::NUM_COEF;
  localparam int AB = ldo_pkg::AD_BASE;
  localparam int BB = ldo_pkg::BD_BASE;

  // request register
  logic                       item_valid_r;
  logic [ldo_pkg::CMD_W-1:0]  item_cmd_r;
  logic signed [OW-1:0]       item_speed_r;
  logic signed [OW-1:0]       item_torque_r;
  logic [IW-1:0]              item_idx_r;
  logic signed [CW-1:0]       item_coef_r;

  // observer state and coefficient store
  logic signed [SW-1:0]       state_r [3];
  logic signed [SW-1:0]       state_nxt [3];
  logic signed [CW-1:0]       coef_r [NC];

  // output queue
  logic                       out_valid_r, out_valid_nxt;
  logic signed [OW-1:0]       out_data_r, out_data_nxt;
  logic                       skid_valid_r, skid_valid_nxt;
  logic signed [OW-1:0]       skid_data_r, skid_data_nxt;

  logic                       is_sample;
  logic                       exec;
  logic                       push;
  logic                       out_take;
  logic signed [OW-1:0]       y;

  // execute unless a sample would overflow the output queue
  assign is_sample = (item_cmd_r == ldo_pkg::CMD_SAMPLE);
  assign exec      = item_valid_r && (!is_sample || !skid_valid_r);
  assign push      = exec && is_sample;
  assign in_stall  = item_valid_r && !exec;
  assign out_take  = out_valid_r && !out_stall;

  // request register load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_cmd_r    <= in_cmd;
      item_speed_r  <= in_motor_speed;
      item_torque_r <= in_torsion_torque;
      item_idx_r    <= in_coef_index;
      item_coef_r   <= in_coef_value;
    end
  end

  // one row of the update per state element
  for (genvar r = 0; r < 3; r++) begin : g_row
    ldo_row #(
      .SIGNAL_WIDTH (SIGNAL_WIDTH)
    ) u_row (
      .x0    (state_r[0]),
      .x1    (state_r[1]),
      .x2    (state_r[2]),
      .u0    (item_speed_r),
      .u1    (item_torque_r),
      .c0    (coef_r[AB + r*3]),
      .c1    (coef_r[AB + r*3 + 1]),
      .c2    (coef_r[AB + r*3 + 2]),
      .d0    (coef_r[BB + r*2]),
      .d1    (coef_r[BB + r*2 + 1]),
      .x_new (state_nxt[r])
    );
  end

  // state update or clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        state_r[i] <= '0;
      end
    end else if (exec) begin
      unique case (item_cmd_r)
        ldo_pkg::CMD_SAMPLE: begin
          for (int i = 0; i < 3; i++) begin
            state_r[i] <= state_nxt[i];
          end
        end
        ldo_pkg::CMD_CLEAR: begin
          for (int i = 0; i < 3; i++) begin
            state_r[i] <= '0;
          end
        end
        ldo_pkg::CMD_WRITE: begin
          state_r <= state_r;
        end
        default: begin
          state_r <= state_r;
        end
      endcase
    end
  end

  // coefficient writes, out-of-range index matches no entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NC; i++) begin
        coef_r[i] <= '0;
      end
    end else if (exec && item_cmd_r == ldo_pkg::CMD_WRITE) begin
      for (int i = 0; i < NC; i++) begin
        if (item_idx_r == IW'(i)) begin
          coef_r[i] <= item_coef_r;
        end
      end
    end
  end

  // third state element brought to 32 bits
  if (SW > OW) begin : g_out_sat
    logic in_range;
    assign in_range = (state_r[2][SW-1:OW-1] == {(SW-OW+1){1'b0}}) ||
                      (state_r[2][SW-1:OW-1] == {(SW-OW+1){1'b1}});
    always_comb begin
      if (in_range) begin
        y = state_r[2][OW-1:0];
      end else if (state_r[2][SW-1]) begin
        y = {1'b1, {(OW-1){1'b0}}};
      end else begin
        y = {1'b0, {(OW-1){1'b1}}};
      end
    end
  end else if (SW < OW) begin : g_out_ext
    assign y = {{(OW-SW){state_r[2][SW-1]}}, state_r[2]};
  end else begin : g_out_same
    assign y = state_r[2][OW-1:0];
  end

  // output queue: output register with one skid entry behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = push;
        skid_data_nxt  = y;
      end else begin
        out_valid_nxt  = push;
        out_data_nxt   = y;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_load_torque = out_data_r;

endmodule

/* verif/testbench.sv */
// self-checking testbench for the load-side disturbance observer
module testbench;

  localparam int SW           = ldo_pkg::SIGNAL_WIDTH;
  localparam int IO_W         = ldo_pkg::IO_W;
  localparam int COEF_W       = ldo_pkg::COEF_W;
  localparam int CMD_W        = ldo_pkg::CMD_W;
  localparam int COEF_IDX_W   = ldo_pkg::COEF_IDX_W;
  localparam int NUM_COEF     = ldo_pkg::NUM_COEF;
  localparam int AD_BASE      = ldo_pkg::AD_BASE;
  localparam int BD_BASE      = ldo_pkg::BD_BASE;
  localparam int FRAC_SHIFT   = ldo_pkg::FRAC_SHIFT;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 10;
  localparam int REPORT_LINES = 200;

  // codes the block must ignore
  localparam logic [CMD_W-1:0]      CMD_UNUSED  = 2'd3;
  localparam logic [COEF_IDX_W-1:0] IDX_IGNORED = COEF_IDX_W'(NUM_COEF);

  // fixed-point landmarks
  localparam logic signed [31:0] V_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] V_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] V_ZERO = 32'sh0000_0000;
  localparam logic signed [31:0] V_LSB  = 32'sh0000_0001;
  localparam logic signed [31:0] V_NEG1 = 32'shFFFF_FFFF;
  localparam logic signed [31:0] V_THREE = 32'sh0000_0003;
  localparam logic signed [31:0] V_NEG3  = 32'shFFFF_FFFD;
  localparam logic signed [31:0] C_ONE  = 32'sh0100_0000;
  localparam logic signed [31:0] C_HALF = 32'sh0080_0000;

  localparam logic signed [95:0] ROUND_HALF = 96'sd1 <<< (FRAC_SHIFT - 1);

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [IO_W-1:0]   speed;
    logic signed [IO_W-1:0]   torque;
    logic [COEF_IDX_W-1:0]    idx;
    logic signed [COEF_W-1:0] value;
    logic                     typed;
    logic signed [IO_W-1:0]   torque_typed;
  } request_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  // directed requests: typed torque only where it is obvious
  localparam int SCRIPT_LEN = 25;
  localparam request_t SCRIPT [SCRIPT_LEN] = '{
    // straight after reset
    '{ldo_pkg::CMD_SAMPLE, V_ZERO, V_ZERO, 4'd0, V_ZERO, 1'b1, V_ZERO},
    // all-zero coefficients keep the state at zero
    '{ldo_pkg::CMD_SAMPLE, V_MAX, V_MIN, 4'd0, V_ZERO, 1'b1, V_ZERO},
    '{ldo_pkg::CMD_WRITE, V_ZERO, V_ZERO, 4'd14, C_ONE, 1'b0, V_ZERO},
    '{ldo_pkg::CMD_WRITE, V_ZERO, V_ZERO, 4'd13, V_MIN, 1'b0, V_ZERO},
    // out-of-range index and unused command change nothing
    '{ldo_pkg::CMD_WRITE, V_ZERO, V_ZERO, IDX_IGNORED, V_MAX, 1'b0, V_ZERO},
    '{CMD_UNUSED, V_MAX, V_MAX, 4'd3, V_MAX, 1'b0, V_ZERO},
    '{ldo_pkg::CMD_SAMPLE, V_ZERO, V_LSB, 4'd0, V_ZERO, 1'b1, V_ZERO},
    '{ldo_pkg::CMD_SAMPLE, V_ZERO, V_ZERO, 4'd0, V_ZERO, 1'b0, V_ZERO},
    // saturation both ways
    '{ldo_pkg::CMD_SAMPLE, V_MAX, V_ZERO, 4'd0, V_ZERO, 1'b0, V_ZERO},
    '{ldo_pkg::CMD_SAMPLE, V_MIN, V_ZERO, 4'd0, V_ZERO, 1'b0, V_ZERO},
    '{ldo_pkg::CMD_SAMPLE, V_ZERO, V_ZERO, 4'd0, V_ZERO, 1'b0, V_ZERO},
    '{ldo_pkg::CMD_CLEAR, V_MAX, V_MAX, 4'd15, V_MAX, 1'b0, V_ZERO},
    '{ldo_pkg::CMD_SAMPLE, V_ZERO, V_ZERO, 4'd0, V_ZERO, 1'b1, V_ZERO},
    // half-lsb rounding, positive and negative
    '{ldo_pkg::CMD_WRITE, V_ZERO, V_ZERO, 4'd13, C_HALF, 1'b0, V_ZERO},
    '{ldo_pkg::CMD_WRITE, V_ZERO, V_ZERO, 4'd14, V_ZERO, 1'b0, V_ZERO},
    '{ldo_pkg::CMD_SAMPLE, V_LSB, V_ZERO, 4'd0, V_ZERO, 1'b0, V_ZERO},
    '{ldo_pkg::CMD_SAMPLE, V_NEG1, V_ZERO, 4'd0, V_ZERO, 1'b0, V_ZERO},
    '{ldo_pkg::CMD_SAMPLE, V_THREE, V_ZERO, 4'd0, V_ZERO, 1'b0, V_ZERO},
    '{ldo_pkg::CMD_SAMPLE, V_NEG3, V_ZERO, 4'd0, V_ZERO, 1'b0, V_ZERO},
    // state feedback through ad
    '{ldo_pkg::CMD_WRITE, V_ZERO, V_ZERO, 4'd0, V_MAX, 1'b0, V_ZERO},
    '{ldo_pkg::CMD_WRITE, V_ZERO, V_ZERO, 4'd8, C_ONE, 1'b0, V_ZERO},
    '{ldo_pkg::CMD_WRITE, V_ZERO, V_ZERO, 4'd6, V_MIN, 1'b0, V_ZERO},
    '{ldo_pkg::CMD_WRITE, V_ZERO, V_ZERO, 4'd9, C_ONE, 1'b0, V_ZERO},
    '{ldo_pkg::CMD_SAMPLE, V_MAX, V_MIN, 4'd0, V_ZERO, 1'b0, V_ZERO},
    '{ldo_pkg::CMD_SAMPLE, V_MIN, V_MAX, 4'd0, V_ZERO, 1'b0, V_ZERO}
  };

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_cmd = ldo_pkg::CMD_SAMPLE;
  logic signed [IO_W-1:0]   in_motor_speed = '0;
  logic signed [IO_W-1:0]   in_torsion_torque = '0;
  logic [COEF_IDX_W-1:0]    in_coef_index = '0;
  logic signed [COEF_W-1:0] in_coef_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [IO_W-1:0]   out_load_torque;

  // predictor copy of the block state
  logic signed [SW-1:0]     obs_x [3] = '{default: '0};
  logic signed [COEF_W-1:0] coef_store [NUM_COEF] = '{default: '0};
  logic signed [IO_W-1:0]   expected_torque [$];

  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  int       rx_left = 0;
  int       rx_phase = 0;
  rx_mode_t rx_mode = RX_FREE;

  load_side_disturbance_observer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_motor_speed   (in_motor_speed),
    .in_torsion_torque(in_torsion_torque),
    .in_coef_index    (in_coef_index),
    .in_coef_value    (in_coef_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_load_torque  (out_load_torque)
  );

  always #5 clk = ~clk;

  // clamp to a signed width
  function automatic logic signed [95:0] saturate(input logic signed [95:0] v, input int width);
    logic signed [95:0] hi;
    logic signed [95:0] lo;
    hi = (96'sd1 <<< (width - 1)) - 96'sd1;
    lo = -hi - 96'sd1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // one observer request: a sample emits x[2], then x = ad*x + bd*u; writes and clears update the copy
  task automatic observer_step(input request_t r, output bit has_result,
                               output logic signed [IO_W-1:0] torque_est);
    logic signed [95:0]   acc;
    logic signed [SW-1:0] next_x [3];
    has_result = 1'b0;
    torque_est = '0;
    case (r.cmd)
      ldo_pkg::CMD_WRITE: begin
        if (r.idx < NUM_COEF) coef_store[r.idx] = signed'(r.value);
      end
      ldo_pkg::CMD_CLEAR: begin
        for (int i = 0; i < 3; i++) obs_x[i] = '0;
      end
      ldo_pkg::CMD_SAMPLE: begin
        has_result = 1'b1;
        torque_est = IO_W'(saturate(96'(obs_x[2]), IO_W));
        for (int i = 0; i < 3; i++) begin
          acc = '0;
          for (int j = 0; j < 3; j++) acc = acc + obs_x[j] * coef_store[AD_BASE + 3 * i + j];
          acc = acc + signed'(r.speed) * coef_store[BD_BASE + 2 * i];
          acc = acc + signed'(r.torque) * coef_store[BD_BASE + 2 * i + 1];
          // round half up, then clamp to the state width
          acc = (acc + ROUND_HALF) >>> FRAC_SHIFT;
          next_x[i] = SW'(saturate(acc, SW));
        end
        obs_x = next_x;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic signed [IO_W-1:0] seen,
                                 input logic signed [IO_W-1:0] wanted);
    if (mismatch_count < REPORT_LINES)
      $display("mismatch at cycle %0d: %s: got %0d, wanted %0d", cycle_count, what, seen, wanted);
    mismatch_count++;
  endtask

  // present one request, wait for acceptance, then maybe leave a gap
  task automatic send_request(input request_t r);
    bit                     has_result;
    logic signed [IO_W-1:0] torque_est;
    int                     gap;
    in_valid          <= 1'b1;
    in_cmd            <= r.cmd;
    in_motor_speed    <= r.speed;
    in_torsion_torque <= r.torque;
    in_coef_index     <= r.idx;
    in_coef_value     <= r.value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    observer_step(r, has_result, torque_est);
    if (has_result) expected_torque.push_back(r.typed ? r.torque_typed : torque_est);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // random signal: mostly moderate, some full range, some extremes
  function automatic logic signed [IO_W-1:0] rand_signal();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return IO_W'(int'($urandom_range(0, 2 * (1 << 20))) - (1 << 20));
    if (sel < 9) return $urandom;
    case ($urandom_range(0, 3))
      0: return V_MAX;
      1: return V_MIN;
      2: return V_ZERO;
      default: return V_NEG1;
    endcase
  endfunction

  // receiver stall pattern in segments of random mode
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_left = $urandom_range(5, 60);
      rx_mode = rx_mode_t'($urandom_range(0, 3));
    end else begin
      rx_left--;
    end
    rx_phase++;
    case (rx_mode)
      RX_LIGHT:    out_stall <= ($urandom_range(0, 2) == 0);
      RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: out_stall <= ((rx_phase % 8) < 5);
      default:     out_stall <= 1'b0;
    endcase
  end

  // result checker
  always @(posedge clk) begin : check_results
    logic signed [IO_W-1:0] wanted;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_torque.size() == 0) begin
        report_mismatch("result with nothing pending", out_load_torque, '0);
      end else begin
        wanted = expected_torque.pop_front();
        if (out_load_torque !== wanted) report_mismatch("load_torque", out_load_torque, wanted);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_torque.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus
  initial begin
    request_t r;
    int       counted;
    int       pick;
    int       span;
    bit       paused;
    counted = 0;
    paused  = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    for (int k = 0; k < SCRIPT_LEN; k++) send_request(SCRIPT[k]);

    // random part, mostly samples with coefficient updates in between
    while (counted < RANDOM_ITEMS) begin
      r        = '0;
      r.speed  = rand_signal();
      r.torque = rand_signal();
      r.idx    = COEF_IDX_W'($urandom_range(0, 15));
      r.value  = $urandom;
      pick     = $urandom_range(0, 99);
      if (pick < 66) begin
        r.cmd = ldo_pkg::CMD_SAMPLE;
      end else if (pick < 90) begin
        r.cmd = ldo_pkg::CMD_WRITE;
        r.idx = ($urandom_range(0, 19) == 0) ? IDX_IGNORED
                                             : COEF_IDX_W'($urandom_range(0, NUM_COEF - 1));
        // ad kept within half, bd within one, so the state mostly stays in range
        span = (r.idx < BD_BASE) ? (1 << 23) : (1 << 24);
        case ($urandom_range(0, 9))
          0: r.value = $urandom;
          1: r.value = ($urandom_range(0, 1) == 0) ? V_MAX : V_MIN;
          2: r.value = ($urandom_range(0, 1) == 0) ? V_ZERO : C_ONE;
          default: r.value = COEF_W'(int'($urandom_range(0, 2 * span)) - span);
        endcase
      end else if (pick < 95) begin
        r.cmd = ldo_pkg::CMD_CLEAR;
      end else begin
        r.cmd = CMD_UNUSED;
      end
      if (r.cmd == ldo_pkg::CMD_SAMPLE || r.cmd == ldo_pkg::CMD_CLEAR ||
          (r.cmd == ldo_pkg::CMD_WRITE && r.idx < NUM_COEF))
        counted++;
      send_request(r);
      // hold off once until the pipeline is empty
      if (!paused && counted >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_torque.size() != 0);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (expected_torque.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
